// File: rtl/pmd_pkg.sv
package pmd_pkg;

  localparam int MaxVertices = 64;
  localparam int WeightBits  = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEARCH,
    ST_RELAX,
    ST_REPORT
  } state_t;

  // Control broadcast to every cell of the chain every cycle.
  typedef struct packed {
    logic init;      // key 0 for vertex 0, else infinity; clear parents and visited flags
    logic relax;     // one weight of the picked row arrives for the cell at rd_col
    logic mark;      // set the visited flag of the cell at pick
  } cell_ctl_t;

endpackage

// File: rtl/pmd_ram.sv
module pmd_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/pmd_cell.sv
// One vertex of the search. Holds the key, parent and visited flag, and
// folds its key into the running minimum, which moves one cell per cycle
// along the chain through a register in every cell.
module pmd_cell #(
  parameter int WeightBits = 16,
  parameter int IdxBits    = 6,
  parameter int Index      = 0
) (
  input  logic                  clk,
  input  pmd_pkg::cell_ctl_t    ctl,
  input  logic [IdxBits-1:0]    rd_col,
  input  logic [IdxBits-1:0]    pick,
  input  logic [WeightBits-1:0] weight,
  input  logic                  active,
  input  logic [WeightBits:0]   min_in_key,
  input  logic [IdxBits-1:0]    min_in_idx,
  input  logic                  min_in_ok,
  output logic [WeightBits:0]   min_out_key,
  output logic [IdxBits-1:0]    min_out_idx,
  output logic                  min_out_ok,
  output logic [WeightBits:0]   key,
  output logic [IdxBits-1:0]    parent,
  output logic                  visited
);

  localparam logic [IdxBits-1:0] MyIdx = IdxBits'(Index);
  localparam logic [WeightBits:0] KeyInf = '1;

  logic [WeightBits:0]  key_r;
  logic [IdxBits-1:0]   parent_r;
  logic                 visited_r;
  logic                 take;
  logic [WeightBits:0]  min_key_r;
  logic [IdxBits-1:0]   min_idx_r;
  logic                 min_ok_r;

  // Strict less-than keeps the lower index on a tie since lower cells come first.
  assign take = active && !visited_r && (key_r != KeyInf) &&
                (!min_in_ok || key_r < min_in_key);

  always_ff @(posedge clk) begin
    min_key_r <= take ? key_r : min_in_key;
    min_idx_r <= take ? MyIdx : min_in_idx;
    min_ok_r  <= take || min_in_ok;
  end

  assign min_out_key = min_key_r;
  assign min_out_idx = min_idx_r;
  assign min_out_ok  = min_ok_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      key_r     <= (Index == 0) ? '0 : KeyInf;
      parent_r  <= '0;
      visited_r <= 1'b0;
    end else begin
      if (ctl.mark && pick == MyIdx) begin
        visited_r <= 1'b1;
      end
      if (ctl.relax && rd_col == MyIdx && weight != '0 && !visited_r &&
          {1'b0, weight} < key_r) begin
        key_r    <= {1'b0, weight};
        parent_r <= pick;
      end
    end
  end

  assign key     = key_r;
  assign parent  = parent_r;
  assign visited = visited_r;

endmodule

// File: rtl/prim_mst_dense_unit.sv
// Channel   Direction  Ports                                  Transfer
// config    in         cfg_we, cfg_vertex_count                clk edge with cfg_we high
// input     in         start, in_edge_weight                   clk edge with start && !busy
// result    out        out_valid, out_child_vertex, ...        one cycle with out_valid high
//
// Loading takes one weight per cycle while start is high; busy stays low while
// weights stream in. After the last weight, the search runs up to n-1 rounds,
// ending early once no unvisited vertex is reachable. Each round waits for the
// running minimum to travel the first n cells of the chain and then streams
// the picked row out of the weight memory (one read port).
// Reporting then waits on the memory read of each child's tree weight.
// Reset clears the control state and the load counter; the cells are cleared
// at the start of every run. The result receiver cannot stall the block.
module prim_mst_dense_unit #(
  parameter int MaxVertices = pmd_pkg::MaxVertices,
  parameter int WeightBits  = pmd_pkg::WeightBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_vertex_count,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  output logic [5:0]  out_child_vertex,
  output logic [5:0]  out_parent_vertex,
  output logic [15:0] out_tree_weight,
  output logic        out_reached,
  output logic        out_last
);

  localparam int IdxBits  = $clog2(MaxVertices);
  localparam int NBits    = IdxBits + 1;
  localparam int Depth    = MaxVertices * MaxVertices;
  localparam int AddrBits = $clog2(Depth);
  localparam int CntBits  = AddrBits + 1;
  localparam logic [NBits-1:0] NMax = NBits'(MaxVertices);

  pmd_pkg::state_t state_r, state_nxt;

  logic [6:0]          vcount_r;
  logic [CntBits-1:0]  load_cnt_r, load_cnt_nxt;
  logic [IdxBits-1:0]  pick_r, pick_nxt;
  logic [NBits-1:0]    col_r, col_nxt;       // search wait / row streaming / report counter
  logic [NBits-1:0]    round_r, round_nxt;
  logic                phase_r, phase_nxt;   // report sub-step
  logic [IdxBits-1:0]  rd_col_r;             // column of the weight now on rd_data
  logic                relax_r;

  logic [NBits-1:0]    n_eff;
  logic [CntBits-1:0]  total;
  logic [AddrBits-1:0] rd_addr;
  logic [WeightBits-1:0] rd_data;
  logic                wr_en;

  pmd_pkg::cell_ctl_t  ctl;

  // Vertex count clamp: 0 acts as 1, large values saturate.
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = NBits'(1);
    end else if ({1'b0, vcount_r} > 8'(NMax)) begin
      n_eff = NMax;
    end else begin
      n_eff = NBits'(vcount_r);
    end
  end

  assign total = CntBits'(n_eff) * CntBits'(n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd64;
    end else if (cfg_we) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  assign wr_en = start && !busy;

  pmd_ram #(.Width(WeightBits), .Depth(Depth)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_cnt_r[AddrBits-1:0]),
    .wr_data (in_edge_weight[WeightBits-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Chain of cells. The minimum found so far moves one cell per cycle, so the
  // tap behind cell n-1 is settled once the minimum has passed through the
  // first n cells with the keys held still.
  logic [WeightBits:0] mk [MaxVertices+1];
  logic [IdxBits-1:0]  mi [MaxVertices+1];
  logic                mo [MaxVertices+1];
  logic [WeightBits:0] key_v    [MaxVertices];
  logic [IdxBits-1:0]  parent_v [MaxVertices];
  logic                vis_v    [MaxVertices];

  assign mk[0] = '0;
  assign mi[0] = '0;
  assign mo[0] = 1'b0;

  for (genvar g = 0; g < MaxVertices; g++) begin : g_cell
    pmd_cell #(.WeightBits(WeightBits), .IdxBits(IdxBits), .Index(g)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .rd_col      (rd_col_r),
      .pick        (pick_r),
      .weight      (rd_data),
      .active      (NBits'(g) < n_eff),
      .min_in_key  (mk[g]),
      .min_in_idx  (mi[g]),
      .min_in_ok   (mo[g]),
      .min_out_key (mk[g+1]),
      .min_out_idx (mi[g+1]),
      .min_out_ok  (mo[g+1]),
      .key         (key_v[g]),
      .parent      (parent_v[g]),
      .visited     (vis_v[g])
    );
  end

  logic [IdxBits-1:0] child;
  logic               child_ok;
  logic [IdxBits-1:0] child_par;

  assign child     = col_r[IdxBits-1:0];
  assign child_ok  = vis_v[child] || (key_v[child] != '1);
  assign child_par = child_ok ? parent_v[child] : '0;

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    pick_nxt     = pick_r;
    col_nxt      = col_r;
    round_nxt    = round_r;
    phase_nxt    = phase_r;
    ctl          = '0;
    busy         = 1'b1;
    rd_addr      = '0;
    unique case (state_r)
      pmd_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (load_cnt_r + 1'b1 >= total) begin
            load_cnt_nxt = '0;
            state_nxt    = pmd_pkg::ST_INIT;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      pmd_pkg::ST_INIT: begin
        ctl.init  = 1'b1;
        round_nxt = '0;
        col_nxt   = '0;
        state_nxt = pmd_pkg::ST_SEARCH;
      end
      pmd_pkg::ST_SEARCH: begin
        // Wait until the minimum has passed through the first n cells.
        if (col_r != n_eff) begin
          col_nxt = col_r + 1'b1;
        end else if (round_r + 1'b1 >= n_eff || !mo[n_eff]) begin
          col_nxt   = NBits'(1);
          phase_nxt = 1'b0;
          state_nxt = (n_eff == NBits'(1)) ? pmd_pkg::ST_LOAD : pmd_pkg::ST_REPORT;
        end else begin
          col_nxt   = '0;
          pick_nxt  = mi[n_eff];
          state_nxt = pmd_pkg::ST_RELAX;
        end
      end
      pmd_pkg::ST_RELAX: begin
        ctl.mark = (col_r == '0);
        rd_addr  = AddrBits'(CntBits'(pick_r) * CntBits'(n_eff) + CntBits'(col_r));
        if (col_r == n_eff) begin
          round_nxt = round_r + 1'b1;
          col_nxt   = '0;
          state_nxt = pmd_pkg::ST_SEARCH;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      pmd_pkg::ST_REPORT: begin
        rd_addr = AddrBits'(CntBits'(child) * CntBits'(n_eff) + CntBits'(child_par));
        if (phase_r) begin
          phase_nxt = 1'b0;
          if (col_r + 1'b1 == n_eff) begin
            state_nxt = pmd_pkg::ST_LOAD;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end else begin
          phase_nxt = 1'b1;
        end
      end
      default: state_nxt = pmd_pkg::ST_LOAD;
    endcase
    ctl.relax = relax_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pmd_pkg::ST_LOAD;
      load_cnt_r <= '0;
      relax_r    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      relax_r    <= (state_r == pmd_pkg::ST_RELAX) && (col_r != n_eff);
      out_valid  <= (state_r == pmd_pkg::ST_REPORT) && phase_r;
    end
  end

  always_ff @(posedge clk) begin
    pick_r   <= pick_nxt;
    col_r    <= col_nxt;
    round_r  <= round_nxt;
    phase_r  <= phase_nxt;
    rd_col_r <= col_r[IdxBits-1:0];
    out_child_vertex  <= 6'(child);
    out_parent_vertex <= 6'(child_par);
    out_tree_weight   <= child_ok ? 16'(rd_data) : '0;
    out_reached       <= child_ok;
    out_last          <= (col_r + 1'b1 == n_eff);
  end

endmodule
